### hw/rtl/cpu8alu_pkg.sv
package cpu8alu_pkg;

    // micro-operation codes
    localparam logic [4:0] CMD_ADC     = 5'd0;
    localparam logic [4:0] CMD_SBC     = 5'd1;
    localparam logic [4:0] CMD_AND     = 5'd2;
    localparam logic [4:0] CMD_ORA     = 5'd3;
    localparam logic [4:0] CMD_EOR     = 5'd4;
    localparam logic [4:0] CMD_ASL     = 5'd5;
    localparam logic [4:0] CMD_LSR     = 5'd6;
    localparam logic [4:0] CMD_ROL     = 5'd7;
    localparam logic [4:0] CMD_ROR     = 5'd8;
    localparam logic [4:0] CMD_BIT     = 5'd9;
    localparam logic [4:0] CMD_CMP     = 5'd10;
    localparam logic [4:0] CMD_CPX     = 5'd11;
    localparam logic [4:0] CMD_CPY     = 5'd12;
    localparam logic [4:0] CMD_INC     = 5'd13;
    localparam logic [4:0] CMD_DEC     = 5'd14;
    localparam logic [4:0] CMD_AAX     = 5'd15;
    localparam logic [4:0] CMD_SET_NZ  = 5'd16;
    localparam logic [4:0] CMD_TEST_N  = 5'd17;
    localparam logic [4:0] CMD_TEST_V  = 5'd18;
    localparam logic [4:0] CMD_TEST_Z  = 5'd19;
    localparam logic [4:0] CMD_TEST_C  = 5'd20;

    // status bit positions
    localparam int FLAG_N = 7;
    localparam int FLAG_V = 6;
    localparam int FLAG_D = 3;
    localparam int FLAG_Z = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic [4:0] command;
        logic [7:0] acc;
        logic [7:0] index_x;
        logic [7:0] index_y;
        logic [7:0] operand;
        logic [7:0] status;
    } req_t;

    typedef struct packed {
        logic [7:0] acc_out;
        logic [7:0] operand_out;
        logic [7:0] status_out;
    } rsp_t;

endpackage

### hw/rtl/cpu8alu_exec.sv
module cpu8alu_exec
    import cpu8alu_pkg::*;
(
    input  req_t req,
    output rsp_t rsp
);

    logic [7:0] a;
    logic [7:0] t;
    logic [7:0] sr;
    logic       cin;
    logic [7:0] add_op;

    logic [9:0] bin_sum;
    logic [9:0] dadd_lo;
    logic [9:0] dadd_lo_adj;
    logic [9:0] dadd_hi;
    logic [9:0] dadd_hi_adj;
    logic [9:0] dsub_lo;
    logic [9:0] dsub_lo_adj;
    logic [9:0] dsub_hi;
    logic [9:0] dsub_hi_adj;
    logic [9:0] arith_sum;
    logic [7:0] arith_res;

    logic [7:0] cmp_reg;
    logic [8:0] cmp_sum;
    logic [7:0] inc_val;
    logic [7:0] dec_val;
    logic [7:0] logic_val;
    logic [7:0] sh_val;
    logic       sh_c;
    logic [7:0] test_mask;

    assign a      = req.acc;
    assign t      = req.operand;
    assign sr     = req.status;
    assign cin    = sr[FLAG_C];
    assign add_op = (req.command == CMD_SBC) ? ~t : t;

    // binary add
    assign bin_sum = {2'b00, a} + {2'b00, add_op} + {9'd0, cin};

    // decimal add: nibble correction on the low digit, then on the high digit
    assign dadd_lo     = {6'd0, a[3:0]} + {6'd0, add_op[3:0]} + {9'd0, cin};
    assign dadd_lo_adj = (dadd_lo >= 10'h00A) ? dadd_lo + 10'h006 : dadd_lo;
    assign dadd_hi     = dadd_lo_adj + {2'b00, a[7:4], 4'h0} + {2'b00, add_op[7:4], 4'h0};
    assign dadd_hi_adj = (dadd_hi >= 10'h0A0) ? dadd_hi + 10'h060 : dadd_hi;

    // decimal subtract on the inverted operand
    assign dsub_lo     = {6'd0, a[3:0]} + {6'd0, add_op[3:0]} + {9'd0, cin};
    assign dsub_lo_adj = (dsub_lo < 10'h010) ? ((dsub_lo + 10'h00A) & 10'h00F) : dsub_lo;
    assign dsub_hi     = dsub_lo_adj + {2'b00, a[7:4], 4'h0} + {2'b00, add_op[7:4], 4'h0};
    assign dsub_hi_adj = (dsub_hi < 10'h100) ? ((dsub_hi + 10'h0A0) & 10'h0FF) : dsub_hi;

    always_comb
    begin
        if (!sr[FLAG_D])
        begin
            arith_sum = bin_sum;
        end
        else if (req.command == CMD_SBC)
        begin
            arith_sum = dsub_hi_adj;
        end
        else
        begin
            arith_sum = dadd_hi_adj;
        end
    end

    assign arith_res = arith_sum[7:0];

    always_comb
    begin
        case (req.command)
            CMD_CPX: cmp_reg = req.index_x;
            CMD_CPY: cmp_reg = req.index_y;
            default: cmp_reg = a;
        endcase
    end

    assign cmp_sum = {1'b0, cmp_reg} + {1'b0, ~t} + 9'd1;
    assign inc_val = t + 8'd1;
    assign dec_val = t - 8'd1;

    always_comb
    begin
        case (req.command)
            CMD_AND: logic_val = a & t;
            CMD_ORA: logic_val = a | t;
            default: logic_val = a ^ t;
        endcase
    end

    // shifts and rotates
    always_comb
    begin
        case (req.command)
            CMD_ASL:
            begin
                sh_val = {t[6:0], 1'b0};
                sh_c   = t[7];
            end
            CMD_LSR:
            begin
                sh_val = {1'b0, t[7:1]};
                sh_c   = t[0];
            end
            CMD_ROL:
            begin
                sh_val = {t[6:0], cin};
                sh_c   = t[7];
            end
            default:
            begin
                sh_val = {cin, t[7:1]};
                sh_c   = t[0];
            end
        endcase
    end

    always_comb
    begin
        case (req.command)
            CMD_TEST_N: test_mask = 8'h01 << FLAG_N;
            CMD_TEST_V: test_mask = 8'h01 << FLAG_V;
            CMD_TEST_Z: test_mask = 8'h01 << FLAG_Z;
            default:    test_mask = 8'h01 << FLAG_C;
        endcase
    end

    always_comb
    begin
        rsp.acc_out     = a;
        rsp.operand_out = t;
        rsp.status_out  = sr;
        case (req.command)
            CMD_ADC, CMD_SBC:
            begin
                rsp.acc_out            = arith_res;
                rsp.operand_out        = add_op;
                rsp.status_out         = sr & 8'h3C;
                rsp.status_out[FLAG_C] = arith_sum >= 10'h100;
                rsp.status_out[FLAG_V] = ((a[7] ^ ~add_op[7]) & (a[7] ^ arith_res[7]));
                rsp.status_out[FLAG_N] = arith_res[7];
                rsp.status_out[FLAG_Z] = arith_res == 8'h00;
            end
            CMD_AND, CMD_ORA, CMD_EOR:
            begin
                rsp.acc_out            = logic_val;
                rsp.status_out[FLAG_N] = logic_val[7];
                rsp.status_out[FLAG_Z] = logic_val == 8'h00;
            end
            CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR:
            begin
                rsp.operand_out        = sh_val;
                rsp.status_out[FLAG_C] = sh_c;
                rsp.status_out[FLAG_N] = sh_val[7];
                rsp.status_out[FLAG_Z] = sh_val == 8'h00;
            end
            CMD_BIT:
            begin
                rsp.status_out[FLAG_N] = t[7];
                rsp.status_out[FLAG_V] = t[6];
                rsp.status_out[FLAG_Z] = (a & t) == 8'h00;
            end
            CMD_CMP, CMD_CPX, CMD_CPY:
            begin
                rsp.status_out[FLAG_C] = cmp_sum[8];
                rsp.status_out[FLAG_N] = cmp_sum[7];
                rsp.status_out[FLAG_Z] = cmp_sum[7:0] == 8'h00;
            end
            CMD_INC:
            begin
                rsp.operand_out        = inc_val;
                rsp.status_out[FLAG_N] = inc_val[7];
                rsp.status_out[FLAG_Z] = inc_val == 8'h00;
            end
            CMD_DEC:
            begin
                rsp.operand_out        = dec_val;
                rsp.status_out[FLAG_N] = dec_val[7];
                rsp.status_out[FLAG_Z] = dec_val == 8'h00;
            end
            CMD_AAX:
            begin
                rsp.operand_out = a & req.index_x;
            end
            CMD_SET_NZ:
            begin
                rsp.status_out[FLAG_N] = t[7];
                rsp.status_out[FLAG_Z] = t == 8'h00;
            end
            CMD_TEST_N, CMD_TEST_V, CMD_TEST_Z, CMD_TEST_C:
            begin
                rsp.operand_out = (((sr ^ t) & test_mask) == 8'h00) ? 8'hFF : 8'h00;
            end
            default:
            begin
                rsp.acc_out     = a;
            end
        endcase
    end

endmodule

### hw/rtl/cpu8_alu_flags_bcd_core.sv
// 8-bit processor alu micro-operation unit, 6502-style flags with decimal mode
//
// channels
//   request: req_valid / req_ready / req (command, acc, index_x, index_y,
//            operand, status), taken when valid and ready are both high
//   result:  rsp_valid / rsp_ready / rsp (acc_out, operand_out, status_out)
//
// path: the request is captured in an input register, the whole operation is one
//   combinational pass through the exec unit, and the result lands in the output
//   register
// throughput: one request per cycle, sustained while rsp_ready is high
//
// stall: when the receiver holds rsp_ready low, the output register keeps
//   its result and the input register keeps the next request; req_ready
//   drops only when both are full, so up to two requests are in flight
// reset: rst_n clears both valid bits; no result is shown until a request
//   has been taken, and payload registers are not cleared
module cpu8_alu_flags_bcd_core
    import cpu8alu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,

    input  logic req_valid,
    output logic req_ready,
    input  req_t req,

    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // input stage
    logic s1_valid_reg;
    logic s1_valid_next;
    req_t s1_req_reg;

    // output stage
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;

    rsp_t exec_rsp;
    logic out_load;
    logic in_load;

    cpu8alu_exec u_exec
    (
        .req (s1_req_reg),
        .rsp (exec_rsp)
    );

    // output register takes a result when it is empty or being drained
    assign out_load = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    // input register is free when empty or its request moves on this cycle
    assign req_ready = !s1_valid_reg || out_load;
    assign in_load   = req_valid && req_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            s1_req_reg <= req;
        end
        if (out_load)
        begin
            rsp_reg <= exec_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a held request in the input stage must not be overwritten
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> (s1_valid_reg && $stable(s1_req_reg)))
        else $error("input stage lost a stalled request");

    // ready only drops with both stages full and the receiver stalling
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (s1_valid_reg && rsp_valid_reg && !rsp_ready))
        else $error("request side stalled without cause");

    // the result register holds the exec output of the request it consumed
    a_rsp_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (rsp_valid_reg && rsp_reg == $past(exec_rsp)))
        else $error("result register does not match exec output");

    // a result never appears without a request in the input stage before it
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid_reg && !s1_valid_reg) |=> !rsp_valid_reg)
        else $error("result appeared with no request in flight");

endmodule

### sim/tb_cpu8_alu_flags_bcd_core.sv
`timescale 1ns / 1ps

module tb_cpu8_alu_flags_bcd_core;
    import cpu8alu_pkg::*;

    // run limits
    localparam int unsigned RANDOM_REQUESTS = 1600;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned DRAIN_CYCLES    = 10;
    // highest code of the 5-bit command field, everything above test_c is unused
    localparam logic [4:0] CMD_LAST_CODE = 5'h1F;

    // one row of the directed part: the request and, where it is obvious,
    // the result typed in by hand
    typedef struct packed {
        req_t req;
        logic typed;
        rsp_t want;
    } alu_vector_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // side channel that travels with the request on the driving side
    logic req_typed;
    rsp_t req_expect;

    // idling on either side is allowed only while this is set
    logic idle_on;

    rsp_t alu_result_q[$];
    alu_vector_t directed_q[$];
    rsp_t oldest_result;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    cpu8_alu_flags_bcd_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // alu predictor
    // ------------------------------------------------------------------

    // n from bit 7, z when the byte is zero, all other bits clear
    function automatic logic [7:0] nz_bits(input logic [7:0] v);
        logic [7:0] f;
        f = 8'h00;
        f[FLAG_N] = v[7];
        f[FLAG_Z] = (v == 8'h00);
        return f;
    endfunction

    // cmp/cpx/cpy: register minus operand, v and bits 2..5 kept
    function automatic logic [7:0] compare_flags(input logic [7:0] lhs, op, sr);
        logic [8:0] diff;
        logic [7:0] f;
        diff = {1'b0, lhs} + {1'b0, ~op} + 9'd1;
        f = (sr & 8'h7C) | nz_bits(diff[7:0]);
        f[FLAG_C] = diff[8];
        return f;
    endfunction

    // adc/sbc core, op already inverted for subtract; returns {acc, status}
    function automatic logic [15:0] add_with_carry(input logic subtract,
                                                   input logic [7:0] a, op, sr);
        logic [9:0] sum;
        logic [7:0] res;
        logic [7:0] f;
        sum = {9'd0, sr[FLAG_C]};
        if (sr[FLAG_D])
        begin
            // decimal: low nibble correction, then high nibble correction
            sum = sum + {6'd0, a[3:0]} + {6'd0, op[3:0]};
            if (subtract)
            begin
                if (sum < 10'h010)
                    sum = (sum + 10'h00A) & 10'h00F;
            end
            else if (sum >= 10'h00A)
                sum = sum + 10'h006;
            sum = sum + {2'b00, a[7:4], 4'h0} + {2'b00, op[7:4], 4'h0};
            if (subtract)
            begin
                if (sum < 10'h100)
                    sum = (sum + 10'h0A0) & 10'h0FF;
            end
            else if (sum >= 10'h0A0)
                sum = sum + 10'h060;
        end
        else
            sum = sum + {2'b00, a} + {2'b00, op};
        res = sum[7:0];
        f = (sr & 8'h3C) | nz_bits(res);
        f[FLAG_C] = (sum >= 10'h100);
        f[FLAG_V] = (a[7] ^ ~op[7]) & (a[7] ^ res[7]);
        return {res, f};
    endfunction

    // flag test: all ones when the chosen status bit equals the operand bit
    function automatic logic [7:0] flag_match(input logic [7:0] sr, op, input int pos);
        return (sr[pos] == op[pos]) ? 8'hFF : 8'h00;
    endfunction

    function automatic rsp_t alu_predict(input req_t r);
        logic [7:0] a;
        logic [7:0] t;
        logic [7:0] sr;
        logic [8:0] w;
        rsp_t res;
        a  = r.acc;
        t  = r.operand;
        sr = r.status;
        case (r.command)
            CMD_ADC:
                {a, sr} = add_with_carry(1'b0, a, t, sr);
            CMD_SBC:
            begin
                // operand goes out inverted
                t = ~t;
                {a, sr} = add_with_carry(1'b1, a, t, sr);
            end
            CMD_AND:
            begin
                a  = a & t;
                sr = (sr & 8'h7D) | nz_bits(a);
            end
            CMD_ORA:
            begin
                a  = a | t;
                sr = (sr & 8'h7D) | nz_bits(a);
            end
            CMD_EOR:
            begin
                a  = a ^ t;
                sr = (sr & 8'h7D) | nz_bits(a);
            end
            CMD_ASL, CMD_ROL:
            begin
                w = {t, (r.command == CMD_ROL) ? sr[FLAG_C] : 1'b0};
                t = w[7:0];
                sr = (sr & 8'h7C) | nz_bits(t);
                sr[FLAG_C] = w[8];
            end
            CMD_LSR:
            begin
                // n always ends up clear
                sr = sr & 8'h7C;
                sr[FLAG_C] = t[0];
                t = t >> 1;
                sr[FLAG_Z] = (t == 8'h00);
            end
            CMD_ROR:
            begin
                w = {sr[FLAG_C], t};
                sr = (sr & 8'h7C) | nz_bits(w[8:1]);
                sr[FLAG_C] = t[0];
                t = w[8:1];
            end
            CMD_BIT:
            begin
                sr = (sr & 8'h3D) | (t & 8'hC0);
                sr[FLAG_Z] = ((a & t) == 8'h00);
            end
            CMD_CMP:
                sr = compare_flags(a, t, sr);
            CMD_CPX:
                sr = compare_flags(r.index_x, t, sr);
            CMD_CPY:
                sr = compare_flags(r.index_y, t, sr);
            CMD_INC:
            begin
                t  = t + 8'd1;
                sr = (sr & 8'h7D) | nz_bits(t);
            end
            CMD_DEC:
            begin
                t  = t - 8'd1;
                sr = (sr & 8'h7D) | nz_bits(t);
            end
            CMD_AAX:
                t = a & r.index_x;  // flags untouched
            CMD_SET_NZ:
                sr = (sr & 8'h7D) | nz_bits(t);
            CMD_TEST_N:
                t = flag_match(sr, t, FLAG_N);
            CMD_TEST_V:
                t = flag_match(sr, t, FLAG_V);
            CMD_TEST_Z:
                t = flag_match(sr, t, FLAG_Z);
            CMD_TEST_C:
                t = flag_match(sr, t, FLAG_C);
            default:
                ;  // unused codes pass everything through
        endcase
        res.acc_out     = a;
        res.operand_out = t;
        res.status_out  = sr;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_row(input logic [4:0] cmd, input logic [7:0] a, x, y, t, sr,
                           input logic typed, input logic [7:0] ea, et, es);
        alu_vector_t v;
        v.req.command  = cmd;
        v.req.acc      = a;
        v.req.index_x  = x;
        v.req.index_y  = y;
        v.req.operand  = t;
        v.req.status   = sr;
        v.typed        = typed;
        v.want.acc_out     = ea;
        v.want.operand_out = et;
        v.want.status_out  = es;
        directed_q.push_back(v);
    endtask

    function automatic logic [7:0] bcd_byte();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    function automatic req_t random_request();
        req_t r;
        int unsigned pick;
        r.acc     = 8'($urandom);
        r.index_x = 8'($urandom);
        r.index_y = 8'($urandom);
        r.operand = 8'($urandom);
        r.status  = 8'($urandom);
        // weight toward add/subtract, they hold most of the logic
        pick = $urandom_range(0, 99);
        if (pick < 5)
            r.command = 5'($urandom_range(CMD_TEST_C + 1, CMD_LAST_CODE));
        else if (pick < 45)
            r.command = ($urandom_range(0, 1) != 0) ? CMD_SBC : CMD_ADC;
        else
            r.command = 5'($urandom_range(CMD_ADC, CMD_TEST_C));
        // decimal mode, mostly with well-formed bcd digits
        if ((r.command == CMD_ADC || r.command == CMD_SBC) && $urandom_range(0, 2) != 0)
        begin
            r.status[FLAG_D] = 1'b1;
            if ($urandom_range(0, 3) != 0)
            begin
                r.acc     = bcd_byte();
                r.operand = bcd_byte();
            end
        end
        // sprinkle in the byte extremes
        case ($urandom_range(0, 15))
            0: r.acc     = 8'h00;
            1: r.acc     = 8'hFF;
            2: r.operand = 8'h00;
            3: r.operand = 8'hFF;
            4: r.index_x = r.operand;
            5: r.index_y = r.operand;
            default: ;
        endcase
        return r;
    endfunction

    // hold valid and payload until the request is taken, then maybe idle
    task automatic send_request(input req_t r, input logic typed, input rsp_t want);
        req        <= r;
        req_typed  <= typed;
        req_expect <= want;
        req_valid  <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(negedge clk);
        end
    endtask

    // stop sending until every pending result has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (alu_result_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic [7:0] want, got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch, expected %02h, got %02h",
                         $realtime, field, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls on rsp_ready
    // ------------------------------------------------------------------
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        rsp_ready <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 11))
                    @(negedge clk);
                rsp_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: pop on each accepted result, push on each accepted request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (alu_result_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result %06h with nothing pending", $realtime, rsp);
                end
                else
                begin
                    oldest_result = alu_result_q.pop_front();
                    check_field("acc_out", oldest_result.acc_out, rsp.acc_out);
                    check_field("operand_out", oldest_result.operand_out, rsp.operand_out);
                    check_field("status_out", oldest_result.status_out, rsp.status_out);
                end
            end
            if (req_valid && req_ready)
                alu_result_q.push_back(req_typed ? req_expect : alu_predict(req));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        alu_vector_t v;
        req_t r;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        req_typed      = 1'b0;
        req_expect     = '0;
        idle_on        = 1'b1;

        // directed rows: cmd, acc, x, y, operand, status, typed, acc', operand', status'
        // binary add wrapping to zero with carry out
        add_row(CMD_ADC, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00, 1'b1, 8'h00, 8'h01, 8'h03);
        // signed overflow into the sign bit
        add_row(CMD_ADC, 8'h7F, 8'h00, 8'h00, 8'h01, 8'h00, 1'b1, 8'h80, 8'h01, 8'hC0);
        // binary subtract 0 - 0 with borrow clear, operand comes back inverted
        add_row(CMD_SBC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 1'b1, 8'h00, 8'hFF, 8'h03);
        // and to zero, other status bits kept
        add_row(CMD_AND, 8'hF0, 8'hFF, 8'h00, 8'h0F, 8'hFF, 1'b1, 8'h00, 8'h0F, 8'h7F);
        add_row(CMD_TEST_N, 8'h12, 8'h00, 8'h00, 8'h80, 8'h80, 1'b1, 8'h12, 8'hFF, 8'h80);
        add_row(CMD_TEST_C, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00);
        // a and x leaves the flags alone
        add_row(CMD_AAX, 8'hFF, 8'h3C, 8'h00, 8'h00, 8'hFF, 1'b1, 8'hFF, 8'h3C, 8'hFF);
        // unused codes, lowest and highest
        add_row(CMD_TEST_C + 5'd1, 8'hA5, 8'h00, 8'hFF, 8'h5A, 8'hFF,
                1'b1, 8'hA5, 8'h5A, 8'hFF);
        add_row(CMD_LAST_CODE, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                1'b1, 8'h00, 8'hFF, 8'h00);
        // decimal add: low nibble correction, high nibble correction with carry
        add_row(CMD_ADC, 8'h09, 8'h00, 8'h00, 8'h01, 8'h08, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_ADC, 8'h99, 8'h00, 8'h00, 8'h01, 8'h08, 1'b0, 8'h00, 8'h00, 8'h00);
        // decimal subtract with borrow through both nibbles, and a plain one
        add_row(CMD_SBC, 8'h00, 8'h00, 8'h00, 8'h01, 8'h09, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SBC, 8'h46, 8'h00, 8'h00, 8'h12, 8'h08, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_ORA, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_EOR, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_ASL, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
        // lsr clears n even when it was set
        add_row(CMD_LSR, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_ROL, 8'h00, 8'h00, 8'h00, 8'h80, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_ROR, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_BIT, 8'h0F, 8'h00, 8'h00, 8'hC0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_CMP, 8'h10, 8'h00, 8'h00, 8'h10, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_CPX, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_CPY, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_INC, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_DEC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SET_NZ, 8'h00, 8'h00, 8'h00, 8'h80, 8'h02, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_TEST_V, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 1'b0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_TEST_Z, 8'h00, 8'h00, 8'h00, 8'h02, 8'h02, 1'b0, 8'h00, 8'h00, 8'h00);

        // hold reset, then release it on a falling edge
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (directed_q[i])
        begin
            v = directed_q[i];
            send_request(v.req, v.typed, v.want);
        end
        wait_drained();

        // random requests; a quiet window in the middle, none at the tail
        for (int unsigned i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == RANDOM_REQUESTS / 2)
                wait_drained();
            idle_on = (i < 1000) || (i >= 1100 && i < RANDOM_REQUESTS - 200);
            r = random_request();
            send_request(r, 1'b0, '0);
        end

        // let every pending result come back, then a few spare cycles
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
